/* rtl/hrt_pkg.sv */
// hrt_pkg: shared types and constants for the request head tokenizer
// beat structs, configuration struct and register indexes; no dependencies
package hrt_pkg;

    localparam int unsigned METHOD_CHARS_DEF = 6;
    localparam int unsigned RQ_DEPTH         = 4;
    localparam int unsigned CFG_AW           = 2;
    localparam int unsigned CFG_DW           = 12;

    localparam logic [CFG_AW-1:0] CFG_PATH_LIMIT  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_KEY_LIMIT   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_VALUE_LIMIT = 2'd2;

    localparam logic [11:0] PATH_LIMIT_RST  = 12'd1999;
    localparam logic [7:0]  KEY_LIMIT_RST   = 8'd99;
    localparam logic [7:0]  VALUE_LIMIT_RST = 8'd99;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] byte_class;
        logic       field_end;
        logic [2:0] method_code;
        logic       headers_done;
        logic [2:0] error_code;
        logic       request_end;
        logic       run_last;
    } res_t;

    typedef struct packed {
        logic [11:0] path_limit;
        logic [7:0]  key_limit;
        logic [7:0]  value_limit;
    } cfg_t;

    // results of one byte, handed to the result queue
    typedef struct packed {
        logic [1:0]      n;
        res_t [1:0]      r;
    } push_t;

endpackage

/* rtl/http_request_head_tokenizer.sv */
// http_request_head_tokenizer: top level, limit registers, engine and result queue
// depends on hrt_pkg, hrt_engine and hrt_resq
//
//   port group   dir  beat                   handshake
//   s_           in   in_beat_t (byte, last) s_valid / s_ready
//   m_           out  res_t (one tag)        m_valid / m_ready
//   cfg_         in   12-bit limit write     cfg_wr_en, no wait
//
// while s_ready is high one byte a cycle enters; the queue takes its tags from in_reg
// a byte can make two tags; the queue drains one a cycle while m_ready is high
// s_ready drops while a byte waits and the four-entry queue holds more than two tags
// aresetn (synchronous) empties both stages and restores the default limits
module http_request_head_tokenizer #(
    parameter int unsigned METHOD_CHARS = hrt_pkg::METHOD_CHARS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  hrt_pkg::in_beat_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output hrt_pkg::res_t                  m_data,
    input  logic                           cfg_wr_en,
    input  logic [hrt_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [hrt_pkg::CFG_DW-1:0]     cfg_wdata
);
    import hrt_pkg::*;

    cfg_t  cfg_reg;
    push_t push;
    logic  q_room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.path_limit  <= PATH_LIMIT_RST;
            cfg_reg.key_limit   <= KEY_LIMIT_RST;
            cfg_reg.value_limit <= VALUE_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_PATH_LIMIT:  cfg_reg.path_limit  <= cfg_wdata;
                CFG_KEY_LIMIT:   cfg_reg.key_limit   <= cfg_wdata[7:0];
                CFG_VALUE_LIMIT: cfg_reg.value_limit <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    hrt_engine #(
        .METHOD_CHARS(METHOD_CHARS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .q_room  (q_room),
        .push    (push)
    );

    hrt_resq u_resq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (q_room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result queue not empty after reset");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.n != 2'd0) |-> q_room)
        else $error("tags pushed without queue room");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.n == 2'd2) |-> (push.r[1].run_last && !push.r[0].run_last))
        else $error("run_last misplaced on a tag pair");

    a_path_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr_en && cfg_addr == CFG_PATH_LIMIT) |=>
        (cfg_reg.path_limit == $past(cfg_wdata)))
        else $error("path limit write lost");

endmodule

/* rtl/hrt_engine.sv */
// hrt_engine: input beat register, tokenizer state and the per-byte step logic
// depends on hrt_pkg; feeds up to two results per byte into hrt_resq
module hrt_engine #(
    parameter int unsigned METHOD_CHARS = hrt_pkg::METHOD_CHARS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  hrt_pkg::in_beat_t s_data,
    input  hrt_pkg::cfg_t    cfg,
    input  logic             q_room,
    output hrt_pkg::push_t   push
);
    import hrt_pkg::*;

    localparam int unsigned MW = 8 * METHOD_CHARS;
    localparam logic [11:0] M_LIMIT = 12'(METHOD_CHARS);

    localparam logic [3:0] PH_METHOD   = 4'd0;
    localparam logic [3:0] PH_PATH     = 4'd1;
    localparam logic [3:0] PH_SKIPLINE = 4'd2;
    localparam logic [3:0] PH_LINE     = 4'd3;
    localparam logic [3:0] PH_KEY      = 4'd4;
    localparam logic [3:0] PH_COLON    = 4'd5;
    localparam logic [3:0] PH_VALUE    = 4'd6;
    localparam logic [3:0] PH_SKIPLF   = 4'd7;
    localparam logic [3:0] PH_BODY     = 4'd8;

    localparam logic [2:0] CLS_METHOD = 3'd0;
    localparam logic [2:0] CLS_PATH   = 3'd1;
    localparam logic [2:0] CLS_KEY    = 3'd2;
    localparam logic [2:0] CLS_VALUE  = 3'd3;
    localparam logic [2:0] CLS_BODY   = 3'd4;
    localparam logic [2:0] CLS_DELIM  = 3'd5;
    localparam logic [2:0] CLS_IGN    = 3'd6;

    localparam logic [2:0] MC_GET     = 3'd0;
    localparam logic [2:0] MC_PUT     = 3'd1;
    localparam logic [2:0] MC_POST    = 3'd2;
    localparam logic [2:0] MC_PATCH   = 3'd3;
    localparam logic [2:0] MC_DELETE  = 3'd4;
    localparam logic [2:0] MC_UNKNOWN = 3'd5;
    localparam logic [2:0] MC_NONE    = 3'd0;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_METHOD = 3'd1;
    localparam logic [2:0] ERR_PATH   = 3'd2;
    localparam logic [2:0] ERR_KEY    = 3'd3;
    localparam logic [2:0] ERR_VALUE  = 3'd4;
    localparam logic [2:0] ERR_TRUNC  = 3'd5;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [23:0] STR_GET    = 24'h474554;
    localparam logic [23:0] STR_PUT    = 24'h505554;
    localparam logic [31:0] STR_POST   = 32'h504F5354;
    localparam logic [39:0] STR_PATCH  = 40'h5041544348;
    localparam logic [47:0] STR_DELETE = 48'h44454C455445;

    typedef struct packed {
        res_t r;
        logic ok;
    } fstep_t;

    function automatic res_t mk(logic [7:0] b, logic [2:0] cls, logic fend,
                                logic [2:0] mcode, logic hd, logic [2:0] err);
        res_t r;
        r.out_byte     = b;
        r.byte_class   = cls;
        r.field_end    = fend;
        r.method_code  = mcode;
        r.headers_done = hd;
        r.error_code   = err;
        r.request_end  = 1'b0;
        r.run_last     = 1'b0;
        return r;
    endfunction

    // one field character against its limit
    function automatic fstep_t fstep(logic [7:0] b, logic [11:0] fc, logic [11:0] lim,
                                     logic [2:0] cls, logic [2:0] err);
        fstep_t f;
        if (fc >= lim) begin
            f.r  = mk(b, CLS_IGN, 1'b0, MC_NONE, 1'b0, err);
            f.ok = 1'b0;
        end else begin
            f.r  = mk(b, cls, 1'b0, MC_NONE, 1'b0, ERR_NONE);
            f.ok = 1'b1;
        end
        return f;
    endfunction

    logic          in_valid_reg;
    in_beat_t      in_reg;
    logic [3:0]    phase_reg, phase_next;
    logic [11:0]   count_reg, count_next;
    logic [MW-1:0] mchars_reg, mchars_next;
    logic          failed_reg, failed_next;
    logic          held_reg, held_next;
    logic          advance;
    res_t [1:0]    res;
    logic [1:0]    nres;

    assign advance = in_valid_reg && q_room;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_METHOD;
            count_reg  <= '0;
            mchars_reg <= '0;
            failed_reg <= 1'b0;
            held_reg   <= 1'b0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            mchars_reg <= mchars_next;
            failed_reg <= failed_next;
            held_reg   <= held_next;
        end
    end

    always_comb begin
        logic [7:0]    b;
        logic          last;
        logic          is_zero;
        logic          ending;
        logic          mid;
        logic          do_key;
        logic          do_val;
        logic          fi;
        logic [2:0]    code;
        logic [3:0]    ph;
        logic [11:0]   fc;
        logic [MW-1:0] mc;
        logic          fl;
        logic          hc;
        fstep_t        fs;

        b       = in_reg.in_byte;
        last    = in_reg.in_last;
        is_zero = (b == 8'd0);
        ending  = is_zero || last;
        ph      = phase_reg;
        fc      = count_reg;
        mc      = mchars_reg;
        fl      = failed_reg;
        hc      = held_reg;
        res     = '0;
        nres    = 2'd0;
        do_key  = 1'b0;
        do_val  = 1'b0;
        mid     = 1'b0;
        fi      = 1'b0;
        code    = MC_UNKNOWN;
        fs      = '0;

        if (is_zero) begin
            if (hc && !fl) begin
                ph = PH_KEY;
                fs = fstep(CH_CR, fc, {4'd0, cfg.key_limit}, CLS_KEY, ERR_KEY);
                res[nres[0]] = fs.r;
                nres = nres + 2'd1;
                if (fs.ok) fc = fc + 12'd1;
                else fl = 1'b1;
            end
            hc  = 1'b0;
            mid = (ph != PH_LINE) && (ph != PH_BODY);
            res[nres[0]] = mk(b, CLS_IGN, 1'b0, MC_NONE, 1'b0,
                              (!fl && mid) ? ERR_TRUNC : ERR_NONE);
            nres = nres + 2'd1;
        end else if (fl) begin
            res[nres[0]] = mk(b, CLS_IGN, 1'b0, MC_NONE, 1'b0, ERR_NONE);
            nres = nres + 2'd1;
        end else begin
            case (ph)
                PH_METHOD: begin
                    if (b == CH_SP) begin
                        if (fc == 12'd3 && mc == MW'(STR_GET)) code = MC_GET;
                        else if (fc == 12'd3 && mc == MW'(STR_PUT)) code = MC_PUT;
                        else if (fc == 12'd4 && mc == MW'(STR_POST)) code = MC_POST;
                        else if (fc == 12'd5 && mc == MW'(STR_PATCH)) code = MC_PATCH;
                        else if (fc == 12'd6 && mc == MW'(STR_DELETE)) code = MC_DELETE;
                        res[nres[0]] = mk(b, CLS_DELIM, 1'b1, code, 1'b0, ERR_NONE);
                        nres = nres + 2'd1;
                        fc = '0;
                        mc = '0;
                        ph = PH_PATH;
                    end else begin
                        fs = fstep(b, fc, M_LIMIT, CLS_METHOD, ERR_METHOD);
                        res[nres[0]] = fs.r;
                        nres = nres + 2'd1;
                        if (fs.ok) begin
                            fc = fc + 12'd1;
                            mc = {mc[MW-9:0], b};
                        end else begin
                            fl = 1'b1;
                        end
                    end
                end
                PH_PATH: begin
                    if (b == CH_SP) begin
                        res[nres[0]] = mk(b, CLS_DELIM, 1'b1, MC_NONE, 1'b0, ERR_NONE);
                        nres = nres + 2'd1;
                        fc = '0;
                        ph = PH_SKIPLINE;
                    end else begin
                        fs = fstep(b, fc, cfg.path_limit, CLS_PATH, ERR_PATH);
                        res[nres[0]] = fs.r;
                        nres = nres + 2'd1;
                        if (fs.ok) fc = fc + 12'd1;
                        else fl = 1'b1;
                    end
                end
                PH_SKIPLINE, PH_SKIPLF: begin
                    res[nres[0]] = mk(b, CLS_DELIM, 1'b0, MC_NONE, 1'b0, ERR_NONE);
                    nres = nres + 2'd1;
                    if (b == CH_LF) ph = PH_LINE;
                end
                PH_LINE: begin
                    if (hc) begin
                        hc = 1'b0;
                        if (b == CH_LF) begin
                            res[0] = mk(CH_CR, CLS_DELIM, 1'b0, MC_NONE, 1'b0, ERR_NONE);
                            res[1] = mk(b, CLS_DELIM, 1'b0, MC_NONE, 1'b1, ERR_NONE);
                            nres = 2'd2;
                            ph = PH_BODY;
                        end else begin
                            // held cr turns out to be a key character
                            ph = PH_KEY;
                            fs = fstep(CH_CR, fc, {4'd0, cfg.key_limit}, CLS_KEY, ERR_KEY);
                            res[nres[0]] = fs.r;
                            nres = nres + 2'd1;
                            if (fs.ok) fc = fc + 12'd1;
                            else fl = 1'b1;
                            if (fl) begin
                                res[nres[0]] = mk(b, CLS_IGN, 1'b0, MC_NONE, 1'b0,
                                                  ERR_NONE);
                                nres = nres + 2'd1;
                            end else begin
                                do_key = 1'b1;
                            end
                        end
                    end else if (b == CH_CR && !last) begin
                        hc = 1'b1;
                    end else begin
                        ph = PH_KEY;
                        do_key = 1'b1;
                    end
                end
                PH_KEY: begin
                    do_key = 1'b1;
                end
                PH_COLON: begin
                    ph = PH_VALUE;
                    if (b == CH_SP) begin
                        res[nres[0]] = mk(b, CLS_DELIM, 1'b0, MC_NONE, 1'b0, ERR_NONE);
                        nres = nres + 2'd1;
                    end else begin
                        do_val = 1'b1;
                    end
                end
                PH_VALUE: begin
                    do_val = 1'b1;
                end
                default: begin
                    res[nres[0]] = mk(b, CLS_BODY, 1'b0, MC_NONE, 1'b0, ERR_NONE);
                    nres = nres + 2'd1;
                end
            endcase

            if (do_key) begin
                if (b == CH_COLON) begin
                    res[nres[0]] = mk(b, CLS_DELIM, 1'b1, MC_NONE, 1'b0, ERR_NONE);
                    nres = nres + 2'd1;
                    fc = '0;
                    ph = PH_COLON;
                end else begin
                    fs = fstep(b, fc, {4'd0, cfg.key_limit}, CLS_KEY, ERR_KEY);
                    res[nres[0]] = fs.r;
                    nres = nres + 2'd1;
                    if (fs.ok) fc = fc + 12'd1;
                    else fl = 1'b1;
                end
            end

            if (do_val) begin
                if (b == CH_CR) begin
                    res[nres[0]] = mk(b, CLS_DELIM, 1'b1, MC_NONE, 1'b0, ERR_NONE);
                    nres = nres + 2'd1;
                    fc = '0;
                    ph = PH_SKIPLF;
                end else begin
                    fs = fstep(b, fc, {4'd0, cfg.value_limit}, CLS_VALUE, ERR_VALUE);
                    res[nres[0]] = fs.r;
                    nres = nres + 2'd1;
                    if (fs.ok) fc = fc + 12'd1;
                    else fl = 1'b1;
                end
            end
        end

        // mark the final result of this byte
        if (nres != 2'd0) begin
            fi = (nres == 2'd2);
            if (ending && !is_zero) begin
                mid = (ph != PH_LINE) && (ph != PH_BODY);
                if (!fl && mid && res[fi].error_code == ERR_NONE) begin
                    res[fi].error_code = ERR_TRUNC;
                end
            end
            if (ending) res[fi].request_end = 1'b1;
            res[fi].run_last = 1'b1;
        end

        if (ending) begin
            ph = PH_METHOD;
            fc = '0;
            mc = '0;
            fl = 1'b0;
            hc = 1'b0;
        end

        phase_next  = ph;
        count_next  = fc;
        mchars_next = mc;
        failed_next = fl;
        held_next   = hc;
    end

    assign push = {(advance ? nres : 2'd0), res};

endmodule

/* rtl/hrt_resq.sv */
// hrt_resq: small result queue taking up to two results a cycle
// depends on hrt_pkg; drives the m_ result channel
module hrt_resq (
    input  logic           aclk,
    input  logic           aresetn,
    input  hrt_pkg::push_t push,
    output logic           room,
    output logic           m_valid,
    input  logic           m_ready,
    output hrt_pkg::res_t  m_data
);
    import hrt_pkg::*;

    localparam int unsigned AW = $clog2(RQ_DEPTH);

    res_t          q_reg [RQ_DEPTH];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (cnt_reg != '0);
    assign m_data  = q_reg[rd_reg];
    assign room    = (cnt_reg <= (AW+1)'(RQ_DEPTH - 2));

    assign wr_next  = wr_reg + AW'(push.n);
    assign rd_next  = rd_reg + AW'(pop);
    assign cnt_next = cnt_reg + (AW+1)'(push.n) - (AW+1)'(pop);

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            q_reg[wr_reg] <= push.r[0];
        end
        if (push.n == 2'd2) begin
            q_reg[wr_reg + AW'(1)] <= push.r[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
